FILE: design/csa_pkg.sv
package csa_pkg;

  localparam int WORD_W    = 64;
  localparam int SECS_W    = 20;
  localparam int GEN_W     = 32;
  localparam int CMD_W     = 3;
  localparam int FRAC_BITS = 40;

  // One million seconds in the fixed-point format, wrapped to the word width.
  localparam logic [WORD_W-1:0] NOW_RESET = WORD_W'(64'd1000000 << FRAC_BITS);

  localparam logic [CMD_W-1:0] CMD_SLEEP  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STEP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADJUST = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BUMP   = 3'd4;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] time_arg;
    logic signed [WORD_W-1:0] freq_arg;
    logic [SECS_W-1:0]        slew_seconds;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] now_time;
    logic signed [WORD_W-1:0] total_correction;
    logic signed [WORD_W-1:0] cur_freq;
    logic signed [WORD_W-1:0] offset_left;
    logic [SECS_W-1:0]        seconds_left;
    logic [GEN_W-1:0]         step_count;
  } out_item_t;

endpackage

FILE: design/csa_stream_if.sv
interface csa_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/csa_alu.sv
module csa_alu (
  input  logic [csa_pkg::WORD_W-1:0] a,
  input  logic [csa_pkg::WORD_W-1:0] b,
  input  csa_pkg::alu_op_t           op,
  output logic [csa_pkg::WORD_W:0]   res
);
  import csa_pkg::*;

  logic [WORD_W-1:0] b_eff;
  logic              carry_in;

  // Subtraction is addition of the inverted operand with a carry in; the carry
  // out then means that a is not below b.
  always_comb begin
    b_eff    = (op == ALU_SUB) ? ~b : b;
    carry_in = (op == ALU_SUB);
    res      = {1'b0, a} + {1'b0, b_eff} + {{WORD_W{1'b0}}, carry_in};
  end

endmodule

FILE: design/clock_slew_adjust_engine_top.sv
// Sleep runs the 64 one-bit steps of the shift-add multiply and a slewing tick those of the
// restoring divide, both on one shared 65-bit adder; one request is in work at a time.
// A new request is taken the cycle after its predecessor's result is loaded into the output
// register. Synchronous active-high reset sets the clock to one million seconds, clears the
// other clock state, the sequencer and the output valid flag, and does not reset the working
// and output data registers.
module clock_slew_adjust_engine_top (
  input  logic          clk,
  input  logic          rst,
  csa_stream_if.sink    in_ch,
  csa_stream_if.source  out_ch
);
  import csa_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NOW   = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_MFIXA = 4'd3;
  localparam logic [3:0] S_MFIXB = 4'd4;
  localparam logic [3:0] S_CORR  = 4'd5;
  localparam logic [3:0] S_BASE  = 4'd6;
  localparam logic [3:0] S_FREQ  = 4'd7;
  localparam logic [3:0] S_ABS   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_SIGN  = 4'd10;
  localparam logic [3:0] S_FADD  = 4'd11;
  localparam logic [3:0] S_OSUB  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  localparam int STEPS_W = $clog2(WORD_W);
  localparam int DIV_PAD = WORD_W - SECS_W - 1;

  logic [3:0] state;

  // Architectural state of the simulated clock.
  logic [WORD_W-1:0] now_reg;
  logic [WORD_W-1:0] correction_reg;
  logic [WORD_W-1:0] freq_reg;
  logic [WORD_W-1:0] base_freq_reg;
  logic [WORD_W-1:0] pending_offset;
  logic [SECS_W-1:0] pending_seconds;
  logic [WORD_W-1:0] adjust_freq_reg;
  logic [GEN_W-1:0]  generation_reg;

  // Request held while it is worked on.
  logic [CMD_W-1:0]  cmd;
  logic [WORD_W-1:0] targ;
  logic [WORD_W-1:0] farg;

  // Working registers of the multiply and divide iterations.
  logic [WORD_W-1:0]  mhi;
  logic [WORD_W-1:0]  mlo;
  logic [WORD_W-1:0]  dq;
  logic [SECS_W-1:0]  rem;
  logic               num_neg;
  logic [STEPS_W-1:0] cnt;

  logic      out_valid;
  out_item_t out_data;

  logic [WORD_W-1:0]   alu_a;
  logic [WORD_W-1:0]   alu_b;
  alu_op_t             alu_op;
  logic [WORD_W:0]     alu_res;
  logic [WORD_W-1:0]   alu_sum;
  logic [2*WORD_W-1:0] prod_full;
  logic [WORD_W-1:0]   prod_field;
  logic                adj_pos;

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  assign alu_sum    = alu_res[WORD_W-1:0];
  assign prod_full  = {mhi, mlo};
  // The scaled product is the 128-bit product shifted right by the fraction width.
  assign prod_field = prod_full[FRAC_BITS +: WORD_W];
  assign adj_pos    = !in_ch.data.time_arg[WORD_W-1] && (in_ch.data.time_arg != '0);

  // Operand selection for the shared adder. Every working state of the sequencer uses it; idle and output do not.
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = ALU_ADD;
    unique case (state)
      S_NOW: begin
        alu_a = now_reg;
        alu_b = targ;
      end
      S_MUL: begin
        // One shift-add step of the unsigned product of the duration and the frequency.
        alu_a = mhi;
        alu_b = mlo[0] ? targ : '0;
      end
      S_MFIXA: begin
        // A negative multiplicand needs the other operand taken off the upper half.
        alu_a  = mhi;
        alu_b  = freq_reg;
        alu_op = ALU_SUB;
      end
      S_MFIXB: begin
        alu_a  = mhi;
        alu_b  = targ;
        alu_op = ALU_SUB;
      end
      S_CORR: begin
        alu_a = correction_reg;
        alu_b = (cmd == CMD_SLEEP) ? prod_field : targ;
      end
      S_BASE: begin
        alu_a = base_freq_reg;
        alu_b = farg;
      end
      S_FREQ: begin
        alu_a = base_freq_reg;
        alu_b = adjust_freq_reg;
      end
      S_ABS: begin
        alu_b  = pending_offset;
        alu_op = ALU_SUB;
      end
      S_DIV: begin
        // Trial subtraction of the restoring divide; the carry out gives the quotient bit.
        alu_a  = {{DIV_PAD{1'b0}}, rem, dq[WORD_W-1]};
        alu_b  = {{(WORD_W-SECS_W){1'b0}}, pending_seconds};
        alu_op = ALU_SUB;
      end
      S_SIGN: begin
        alu_b  = dq;
        alu_op = ALU_SUB;
      end
      S_FADD: begin
        alu_a = freq_reg;
        alu_b = dq;
      end
      S_OSUB: begin
        alu_a  = pending_offset;
        alu_b  = dq;
        alu_op = ALU_SUB;
      end
      default: begin
      end
    endcase
  end

  csa_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .op  (alu_op),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      now_reg         <= NOW_RESET;
      correction_reg  <= '0;
      freq_reg        <= '0;
      base_freq_reg   <= '0;
      pending_offset  <= '0;
      pending_seconds <= '0;
      adjust_freq_reg <= '0;
      generation_reg  <= '0;
      cnt             <= '0;
      out_valid       <= 1'b0;
    end else begin
      // In the output state the valid flag is decided there, so it is left alone here.
      if (out_valid && out_ch.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd  <= in_ch.data.cmd;
            targ <= in_ch.data.time_arg;
            farg <= in_ch.data.freq_arg;
            unique case (in_ch.data.cmd)
              CMD_SLEEP: state <= S_NOW;
              CMD_STEP:  state <= S_CORR;
              CMD_ADJUST: begin
                // A positive offset with no seconds given is applied whole at the next tick.
                pending_offset  <= in_ch.data.time_arg;
                pending_seconds <= (adj_pos && (in_ch.data.slew_seconds == '0))
                                   ? SECS_W'(1) : in_ch.data.slew_seconds;
                adjust_freq_reg <= in_ch.data.freq_arg;
                state           <= S_OUT;
              end
              CMD_TICK:  state <= S_FREQ;
              CMD_BUMP:  state <= S_BASE;
              default:   state <= S_OUT;
            endcase
          end
        end
        S_NOW: begin
          now_reg <= alu_sum;
          mhi     <= '0;
          mlo     <= freq_reg;
          cnt     <= '0;
          state   <= S_MUL;
        end
        S_MUL: begin
          mhi <= alu_res[WORD_W:1];
          mlo <= {alu_res[0], mlo[WORD_W-1:1]};
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            state <= S_MFIXA;
          end
        end
        S_MFIXA: begin
          if (targ[WORD_W-1]) begin
            mhi <= alu_sum;
          end
          state <= S_MFIXB;
        end
        S_MFIXB: begin
          if (freq_reg[WORD_W-1]) begin
            mhi <= alu_sum;
          end
          state <= S_CORR;
        end
        S_CORR: begin
          correction_reg <= alu_sum;
          if (cmd == CMD_STEP) begin
            generation_reg <= generation_reg + 1'b1;
          end
          state <= S_OUT;
        end
        S_BASE: begin
          base_freq_reg <= alu_sum;
          state         <= S_CORR;
        end
        S_FREQ: begin
          freq_reg <= alu_sum;
          state    <= (pending_seconds == '0) ? S_OUT : S_ABS;
        end
        S_ABS: begin
          num_neg <= pending_offset[WORD_W-1];
          dq      <= pending_offset[WORD_W-1] ? alu_sum : pending_offset;
          rem     <= '0;
          cnt     <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          rem <= alu_res[WORD_W] ? alu_res[SECS_W-1:0] : {rem[SECS_W-2:0], dq[WORD_W-1]};
          dq  <= {dq[WORD_W-2:0], alu_res[WORD_W]};
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            state <= S_SIGN;
          end
        end
        S_SIGN: begin
          // The quotient of the magnitude takes the sign of the offset back.
          if (num_neg) begin
            dq <= alu_sum;
          end
          state <= S_FADD;
        end
        S_FADD: begin
          freq_reg <= alu_sum;
          state    <= S_OSUB;
        end
        S_OSUB: begin
          pending_offset  <= alu_sum;
          pending_seconds <= pending_seconds - 1'b1;
          state           <= S_OUT;
        end
        S_OUT: begin
          // The result waits here only while the previous one has not been taken.
          if (!out_valid || out_ch.ready) begin
            out_valid                 <= 1'b1;
            out_data.now_time         <= now_reg;
            out_data.total_correction <= correction_reg;
            out_data.cur_freq         <= freq_reg;
            out_data.offset_left      <= pending_offset;
            out_data.seconds_left     <= pending_seconds;
            out_data.step_count       <= generation_reg;
            state                     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A new result only ever appears from the output state.
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside the output state");

  // The multiply leaves after exactly a full run of its step counter.
  a_mul_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_MFIXA) |-> ($past(state) == S_MUL) && (cnt == '0))
    else $error("multiply left before all steps were done");

  // A restoring divide always ends with a remainder below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_SIGN) |-> (rem < pending_seconds))
    else $error("divide remainder not below divisor");

  // Each slewing tick consumes exactly one second.
  a_secs_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_OSUB) |=> (pending_seconds == SECS_W'($past(pending_seconds) - 1'b1)))
    else $error("slew seconds not decremented by one");

  // The step count moves only on a step request or on reset.
  a_gen_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(generation_reg) |->
      $past(rst) || (($past(state) == S_CORR) && ($past(cmd) == CMD_STEP)))
    else $error("step count changed outside a step");

endmodule
